/* rtl/core/frj_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Record journal package
// Shared types, constants and command/status structures for the journal.
// ----------------------------------------------------------------------------
package frj_pkg;

    localparam int unsigned RECORDS   = 1024;
    localparam int unsigned REC_W     = $clog2(RECORDS);
    localparam int unsigned WADDR_W   = REC_W + 2;

    localparam logic [31:0] TAG_SCORE    = 32'h5343_4F52;
    localparam logic [31:0] TAG_SETTINGS = 32'h5345_5454;
    localparam logic [31:0] CHECK_SEED   = 32'hA5A5_5A5A;
    localparam logic [31:0] ERASED_WORD  = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_READ_SCORE    = 2'd0,
        KIND_READ_SETTINGS = 2'd1,
        KIND_SAVE_SCORE    = 2'd2,
        KIND_SAVE_SETTINGS = 2'd3
    } kind_t;

    typedef struct packed {
        logic             scan_start;
        logic             rd_en;
        logic [REC_W-1:0] rd_rec;
        logic [1:0]       rd_word;
        logic             eval;
        logic [REC_W-1:0] eval_rec;
        logic             wr_en;
        logic [REC_W-1:0] wr_rec;
        logic [1:0]       wr_word;
        logic             wr_other;
        logic             wr_erased;
    } frj_cmd_t;

    typedef struct packed {
        logic             rec_erased;
        logic             sc_found;
        logic             st_found;
        logic [REC_W-1:0] end_rec;
        logic             full;
    } frj_sts_t;

endpackage
`default_nettype wire

/* rtl/core/frj_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Journal channel interfaces
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface frj_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] value;
    modport source (output valid, kind, address, value, input ready);
    modport sink (input valid, kind, address, value, output ready);
endinterface

interface frj_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] result_value;
    logic        ok;
    modport source (output valid, result_value, ok, input ready);
    modport sink (input valid, result_value, ok, output ready);
endinterface
`default_nettype wire

/* rtl/core/frj_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Journal datapath
// Record store, record assembly, newest-record trackers and write data.
// ----------------------------------------------------------------------------
module frj_datapath (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire frj_pkg::frj_cmd_t cmd,
    input  wire logic          is_score,
    input  wire logic [31:0]   save_value,
    output frj_pkg::frj_sts_t  sts,
    output logic [31:0]        sc_val,
    output logic [31:0]        st_val
);

    logic [31:0] mem [0:frj_pkg::RECORDS*4-1];
    logic [31:0] rd_data_reg;
    logic        rd_valid_reg;
    logic [1:0]  rd_word_reg;
    logic [31:0] w0_reg, w1_reg, w2_reg;
    logic        erased_reg;
    logic        sc_found_reg, st_found_reg;
    logic [31:0] sc_seq_reg, sc_val_reg, st_seq_reg, st_val_reg;
    logic [frj_pkg::REC_W-1:0] end_rec_reg;
    logic        full_reg;
    logic        rec_erased_reg;
    logic [31:0] wr_tag, wr_seq, wr_val, wr_data;
    logic [31:0] my_seq;
    logic        my_found;
    logic [31:0] d_sc, d_st;
    logic        chk_ok, take_sc, take_st;
    logic [frj_pkg::WADDR_W-1:0] waddr, raddr;

    assign raddr = {cmd.rd_rec, cmd.rd_word};
    assign waddr = {cmd.wr_rec, cmd.wr_word};

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[raddr];
        end
        if (cmd.wr_en)
        begin
            mem[waddr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            rd_word_reg  <= 2'd0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            rd_word_reg  <= cmd.rd_word;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            case (rd_word_reg)
                2'd0: w0_reg <= rd_data_reg;
                2'd1: w1_reg <= rd_data_reg;
                2'd2: w2_reg <= rd_data_reg;
                default: ;
            endcase
        end
    end

    assign d_sc = w1_reg - sc_seq_reg;
    assign d_st = w1_reg - st_seq_reg;
    assign chk_ok = (rd_data_reg == (w0_reg ^ w1_reg ^ w2_reg ^ frj_pkg::CHECK_SEED));
    assign take_sc = chk_ok && w0_reg == frj_pkg::TAG_SCORE &&
                     (!sc_found_reg || (d_sc != 32'd0 && !d_sc[31]));
    assign take_st = chk_ok && w0_reg == frj_pkg::TAG_SETTINGS &&
                     (!st_found_reg || (d_st != 32'd0 && !d_st[31]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_found_reg   <= 1'b0;
            st_found_reg   <= 1'b0;
            sc_seq_reg     <= 32'd0;
            st_seq_reg     <= 32'd0;
            sc_val_reg     <= 32'd0;
            st_val_reg     <= 32'd0;
            erased_reg     <= 1'b1;
            rec_erased_reg <= 1'b0;
            end_rec_reg    <= '0;
            full_reg       <= 1'b0;
        end
        else if (cmd.scan_start)
        begin
            sc_found_reg   <= 1'b0;
            st_found_reg   <= 1'b0;
            erased_reg     <= 1'b1;
            rec_erased_reg <= 1'b0;
            full_reg       <= 1'b1;
        end
        else
        begin
            rec_erased_reg <= 1'b0;
            if (rd_valid_reg)
            begin
                if (rd_word_reg == 2'd0)
                begin
                    erased_reg <= (rd_data_reg == frj_pkg::ERASED_WORD);
                end
                else if (rd_data_reg != frj_pkg::ERASED_WORD)
                begin
                    erased_reg <= 1'b0;
                end
            end
            if (cmd.eval)
            begin
                if (erased_reg && rd_data_reg == frj_pkg::ERASED_WORD)
                begin
                    rec_erased_reg <= 1'b1;
                    end_rec_reg    <= cmd.eval_rec;
                    full_reg       <= 1'b0;
                end
                else
                begin
                    if (take_sc)
                    begin
                        sc_found_reg <= 1'b1;
                        sc_seq_reg   <= w1_reg;
                        sc_val_reg   <= w2_reg;
                    end
                    if (take_st)
                    begin
                        st_found_reg <= 1'b1;
                        st_seq_reg   <= w1_reg;
                        st_val_reg   <= w2_reg;
                    end
                end
            end
        end
    end

    assign my_found = is_score ? sc_found_reg : st_found_reg;
    assign my_seq   = is_score ? sc_seq_reg : st_seq_reg;

    always_comb
    begin
        if (cmd.wr_other)
        begin
            wr_tag = is_score ? frj_pkg::TAG_SETTINGS : frj_pkg::TAG_SCORE;
            wr_seq = is_score ? st_seq_reg : sc_seq_reg;
            wr_val = is_score ? st_val_reg : sc_val_reg;
        end
        else
        begin
            wr_tag = is_score ? frj_pkg::TAG_SCORE : frj_pkg::TAG_SETTINGS;
            wr_seq = my_found ? my_seq + 32'd1 : 32'd0;
            wr_val = save_value;
        end
        if (cmd.wr_erased)
        begin
            wr_data = frj_pkg::ERASED_WORD;
        end
        else
        begin
            case (cmd.wr_word)
                2'd0: wr_data = wr_tag;
                2'd1: wr_data = wr_seq;
                2'd2: wr_data = wr_val;
                default: wr_data = wr_tag ^ wr_seq ^ wr_val ^ frj_pkg::CHECK_SEED;
            endcase
        end
    end

    assign sts.rec_erased = rec_erased_reg;
    assign sts.sc_found   = sc_found_reg;
    assign sts.st_found   = st_found_reg;
    assign sts.end_rec    = end_rec_reg;
    assign sts.full       = full_reg;
    assign sc_val = sc_val_reg;
    assign st_val = st_val_reg;

endmodule
`default_nettype wire

/* rtl/core/frj_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Journal controller
// Sequences the clearing pass, the store scan, the erase and the appends.
// ----------------------------------------------------------------------------
module frj_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              do_scan,
    input  wire logic              do_save,
    input  wire logic              is_score,
    input  wire frj_pkg::frj_sts_t sts,
    output frj_pkg::frj_cmd_t      cmd,
    output logic                   idle,
    output logic                   done
);

    typedef enum logic [8:0] {
        ST_CLEAR  = 9'b000000001,
        ST_IDLE   = 9'b000000010,
        ST_SCAN   = 9'b000000100,
        ST_DRAIN  = 9'b000001000,
        ST_DECIDE = 9'b000010000,
        ST_ERASE  = 9'b000100000,
        ST_OTHER  = 9'b001000000,
        ST_WRITE  = 9'b010000000,
        ST_DONE   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    logic [frj_pkg::REC_W-1:0] rec_reg, rec_next;
    logic [1:0] word_reg, word_next;
    logic [frj_pkg::REC_W-1:0] eval_rec_reg;
    logic [2:0] pipe_reg;
    logic [frj_pkg::REC_W-1:0] tgt_reg, tgt_next;
    logic last_rec;
    logic other_found;

    assign last_rec = (rec_reg == frj_pkg::REC_W'(frj_pkg::RECORDS - 1));
    assign other_found = is_score ? sts.st_found : sts.sc_found;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            rec_reg      <= '0;
            word_reg     <= 2'd0;
            tgt_reg      <= '0;
            pipe_reg     <= 3'd0;
            eval_rec_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            rec_reg   <= rec_next;
            word_reg  <= word_next;
            tgt_reg   <= tgt_next;
            pipe_reg  <= {pipe_reg[1:0], (state_reg == ST_SCAN && word_reg == 2'd3)};
            if (state_reg == ST_SCAN && word_reg == 2'd3)
            begin
                eval_rec_reg <= rec_reg;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rec_next   = rec_reg;
        word_next  = word_reg;
        tgt_next   = tgt_reg;
        cmd        = '0;
        cmd.rd_rec = rec_reg;
        cmd.rd_word = word_reg;
        cmd.wr_rec = rec_reg;
        cmd.wr_word = word_reg;
        cmd.eval   = pipe_reg[0];
        cmd.eval_rec = eval_rec_reg;
        done = 1'b0;
        unique case (state_reg) inside
            ST_CLEAR, ST_ERASE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_erased = 1'b1;
                word_next     = word_reg + 2'd1;
                if (word_reg == 2'd3)
                begin
                    rec_next = rec_reg + frj_pkg::REC_W'(1);
                    if (last_rec)
                    begin
                        rec_next = '0;
                        if (state_reg == ST_CLEAR)
                        begin
                            state_next = ST_IDLE;
                        end
                        else if (other_found)
                        begin
                            state_next = ST_OTHER;
                        end
                        else
                        begin
                            tgt_next   = '0;
                            state_next = ST_WRITE;
                        end
                    end
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    if (do_scan)
                    begin
                        cmd.scan_start = 1'b1;
                        rec_next   = '0;
                        word_next  = 2'd0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.rec_erased)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_rec = rec_reg;
                    word_next  = word_reg + 2'd1;
                    if (word_reg == 2'd3)
                    begin
                        rec_next = rec_reg + frj_pkg::REC_W'(1);
                        if (last_rec)
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                end
            end
            ST_DRAIN:
            begin
                if (pipe_reg == 3'd0 && !sts.rec_erased)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                rec_next  = '0;
                word_next = 2'd0;
                if (!do_save)
                begin
                    state_next = ST_DONE;
                end
                else if (sts.full)
                begin
                    state_next = ST_ERASE;
                end
                else
                begin
                    tgt_next   = sts.end_rec;
                    state_next = ST_WRITE;
                end
            end
            ST_OTHER:
            begin
                cmd.wr_en    = 1'b1;
                cmd.wr_other = 1'b1;
                cmd.wr_rec   = '0;
                word_next    = word_reg + 2'd1;
                if (word_reg == 2'd3)
                begin
                    tgt_next   = frj_pkg::REC_W'(1);
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                cmd.wr_en  = 1'b1;
                cmd.wr_rec = tgt_reg;
                word_next  = word_reg + 2'd1;
                if (word_reg == 2'd3)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                done       = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign idle = (state_reg == ST_IDLE);

endmodule
`default_nettype wire

/* rtl/core/flash_record_journal.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Flash record journal
// Append-only journal of score and settings records in an erasable store.
// Records are scanned and written one word a cycle through the store; a
// full store is erased before the append. One request at a time. After
// reset a clearing pass erases the store first.
// ----------------------------------------------------------------------------
module flash_record_journal (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  wire logic [31:0] cfg_wdata,
    frj_req_if.sink    req,
    frj_rsp_if.source  rsp
);

    logic [31:0] base_reg;
    logic [1:0]  kind_reg;
    logic        addr_ok_reg;
    logic [31:0] value_reg;
    logic        busy_reg;
    logic        rsp_valid_reg;
    logic [31:0] rsp_value_reg;
    logic        rsp_ok_reg;
    logic        start, idle, done, is_score, do_scan, do_save;
    logic        found_flag;
    logic [31:0] rsp_val_d;
    logic [31:0] sc_val, st_val;
    frj_pkg::frj_cmd_t cmd;
    frj_pkg::frj_sts_t sts;

    assign is_score = (kind_reg == frj_pkg::KIND_READ_SCORE) ||
                      (kind_reg == frj_pkg::KIND_SAVE_SCORE);
    assign do_scan  = !is_score || addr_ok_reg;
    assign do_save  = kind_reg[1];
    assign req.ready = idle && !busy_reg && !rsp_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= 32'd0;
            busy_reg      <= 1'b0;
            kind_reg      <= 2'd0;
            addr_ok_reg   <= 1'b0;
            rsp_valid_reg <= 1'b0;
            rsp_ok_reg    <= 1'b0;
            rsp_value_reg <= 32'd0;
            value_reg     <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                base_reg <= cfg_wdata;
            end
            if (req.valid && req.ready)
            begin
                busy_reg    <= 1'b1;
                kind_reg    <= req.kind;
                addr_ok_reg <= (req.address == base_reg);
                value_reg   <= req.value;
            end
            else if (start)
            begin
                busy_reg <= 1'b0;
            end
            if (done)
            begin
                rsp_valid_reg <= 1'b1;
                rsp_ok_reg    <= found_flag;
                rsp_value_reg <= rsp_val_d;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign start = busy_reg && idle;

    always_comb
    begin
        found_flag = 1'b0;
        unique case (kind_reg)
            frj_pkg::KIND_READ_SCORE:    found_flag = addr_ok_reg && sts.sc_found;
            frj_pkg::KIND_READ_SETTINGS: found_flag = sts.st_found;
            frj_pkg::KIND_SAVE_SCORE:    found_flag = addr_ok_reg;
            default:                     found_flag = 1'b1;
        endcase
    end

    always_comb
    begin
        rsp_val_d = 32'd0;
        unique case (kind_reg)
            frj_pkg::KIND_READ_SCORE:
                rsp_val_d = (addr_ok_reg && sts.sc_found) ? sc_val : 32'd0;
            frj_pkg::KIND_READ_SETTINGS:
                rsp_val_d = sts.st_found ? st_val : value_reg;
            default:
                rsp_val_d = 32'd0;
        endcase
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.result_value = rsp_value_reg;
    assign rsp.ok           = rsp_ok_reg;

    frj_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .do_scan  (do_scan),
        .do_save  (do_save),
        .is_score (is_score),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle),
        .done     (done)
    );

    frj_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .is_score   (is_score),
        .save_value (value_reg),
        .sts        (sts),
        .sc_val     (sc_val),
        .st_val     (st_val)
    );

`ifndef SYNTHESIS
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid)
        else $error("response dropped while stalled");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.ready)
        else $error("request accepted while busy");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> idle)
        else $error("controller not idle after done");
`endif

endmodule
`default_nettype wire
